FILE: rtl/core/pgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_pkg
// Shared widths, types and the reciprocal table for the gradient fill unit.
// ----------------------------------------------------------------------------
package pgf_pkg;

   localparam int IDX_W           = 5;
   localparam int COLOR_W         = 12;
   localparam int CHAN_W          = 4;
   localparam int CHANNELS        = 3;
   localparam int PALETTE_ENTRIES = 32;
   // wide enough to compare an index against the palette size
   localparam int PAL_CMP_W       = 9;

   localparam logic [CHAN_W-1:0] CHAN_MASK = 4'hf;

   // k * |delta|: 5 bits by 4 bits
   localparam int PROD_W      = IDX_W + CHAN_W;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int FULL_W      = PROD_W + RECIP_W;

   // ceil(2^16 / span); exact for k*|delta| < 512 and span < 32
   localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
      17'd0,     17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108,
      17'd10923, 17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,
      17'd5462,  17'd5042,  17'd4682,  17'd4370,  17'd4096,  17'd3856,
      17'd3641,  17'd3450,  17'd3277,  17'd3121,  17'd2979,  17'd2850,
      17'd2731,  17'd2622,  17'd2521,  17'd2428,  17'd2341,  17'd2260,
      17'd2185,  17'd2115
   };

   // one entry of a run, handed from the sequencer to the blend pipeline
   typedef struct packed {
      logic [IDX_W-1:0]   k;
      logic [IDX_W-1:0]   span;
      logic [IDX_W-1:0]   index;
      logic [COLOR_W-1:0] start_color;
      logic [COLOR_W-1:0] end_color;
      logic               last;
   } pgf_work_type;

endpackage

FILE: rtl/core/pgf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_req_if / pgf_rsp_if
// Valid/ready channels for gradient requests and palette entry results.
// ----------------------------------------------------------------------------
interface pgf_req_if;
   logic                        valid;
   logic                        ready;
   logic [pgf_pkg::IDX_W-1:0]   start_index;
   logic [pgf_pkg::IDX_W-1:0]   end_index;
   logic [pgf_pkg::COLOR_W-1:0] start_color;
   logic [pgf_pkg::COLOR_W-1:0] end_color;

   modport source (output valid, start_index, end_index, start_color, end_color,
                   input ready);
   modport sink   (input valid, start_index, end_index, start_color, end_color,
                   output ready);
endinterface

interface pgf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pgf_pkg::IDX_W-1:0]   entry_index;
   logic [pgf_pkg::COLOR_W-1:0] entry_color;
   logic                        last_entry;

   modport source (output valid, entry_index, entry_color, last_entry,
                   input ready);
   modport sink   (input valid, entry_index, entry_color, last_entry,
                   output ready);
endinterface

FILE: rtl/core/palette_gradient_fill_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_gradient_fill_unit
// Linear RGB444 gradient over a palette range, one entry per transfer.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    start_index, end_index, start_color, end_color
//   rsp_ch   out  valid/ready    entry_index, entry_color, last_entry
//
// A request of span s yields s entries, one per cycle while rsp_ch is ready;
// the first is presented on rsp_ch after it passes the sequencer and the
// blend stages. The next request is taken once the last entry is issued.
// Empty or out-of-palette requests are taken and produce nothing.
// Reset is synchronous and clears the sequencer state and pipeline valids.
// A stall on rsp_ch holds the pipeline in place and backs up into req_ch.
// ----------------------------------------------------------------------------
module palette_gradient_fill_unit (
   input  logic      clock,
   input  logic      reset,
   pgf_req_if.sink   req_ch,
   pgf_rsp_if.source rsp_ch
);

   pgf_pkg::pgf_work_type work;
   logic                  work_valid;
   logic                  work_ready;

   pgf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .work_valid (work_valid),
      .work_ready (work_ready),
      .work       (work)
   );

   pgf_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_ready (work_ready),
      .work       (work),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: rtl/core/pgf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_seq
// Takes one request and steps k through the run, one entry per transfer.
// ----------------------------------------------------------------------------
module pgf_seq (
   input  logic                  clock,
   input  logic                  reset,
   pgf_req_if.sink               req_ch,
   output logic                  work_valid,
   input  logic                  work_ready,
   output pgf_pkg::pgf_work_type work
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type                   state_ff;
   logic [pgf_pkg::IDX_W-1:0]   k_ff;
   logic [pgf_pkg::IDX_W-1:0]   span_ff;
   logic [pgf_pkg::IDX_W-1:0]   base_ff;
   logic [pgf_pkg::COLOR_W-1:0] scol_ff;
   logic [pgf_pkg::COLOR_W-1:0] ecol_ff;

   logic req_fire;
   logic in_range;
   logic is_last;
   logic advance;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_range =
      ({{(pgf_pkg::PAL_CMP_W-pgf_pkg::IDX_W){1'b0}}, req_ch.start_index}
         < pgf_pkg::PAL_CMP_W'(pgf_pkg::PALETTE_ENTRIES)) &&
      ({{(pgf_pkg::PAL_CMP_W-pgf_pkg::IDX_W){1'b0}}, req_ch.end_index}
         < pgf_pkg::PAL_CMP_W'(pgf_pkg::PALETTE_ENTRIES)) &&
      (req_ch.end_index > req_ch.start_index);

   assign is_last    = (k_ff == span_ff - pgf_pkg::IDX_W'(1));
   assign work_valid = (state_ff == ST_RUN);
   assign advance    = work_valid && work_ready;

   always_comb begin
      work.k           = k_ff;
      work.span        = span_ff;
      work.index       = base_ff + k_ff;
      work.start_color = scol_ff;
      work.end_color   = ecol_ff;
      work.last        = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               // empty or out-of-palette requests are taken and dropped
               if (req_fire && in_range) begin
                  state_ff <= ST_RUN;
                  k_ff     <= '0;
                  span_ff  <= req_ch.end_index - req_ch.start_index;
                  base_ff  <= req_ch.start_index;
                  scol_ff  <= req_ch.start_color;
                  ecol_ff  <= req_ch.end_color;
               end
            end
            ST_RUN: begin
               if (advance) begin
                  if (is_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff <= k_ff + pgf_pkg::IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_k_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (k_ff < span_ff))
      else $error("pgf_seq: offset reached span");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (advance && is_last) |=> (state_ff == ST_IDLE))
      else $error("pgf_seq: run continued past last entry");

endmodule

FILE: rtl/core/pgf_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_blend
// Three-stage channel interpolator: k*|delta|, times reciprocal of span,
// then shift, sign and add to the start channel.
// ----------------------------------------------------------------------------
module pgf_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  work_valid,
   output logic                  work_ready,
   input  pgf_pkg::pgf_work_type work,
   pgf_rsp_if.source             rsp_ch
);

   localparam int CW = pgf_pkg::CHAN_W;
   localparam int NC = pgf_pkg::CHANNELS;
   localparam int SW = pgf_pkg::PROD_W + 1;

   // stage 1: |delta| product and reciprocal lookup
   logic                             v1_ff;
   logic [NC-1:0][pgf_pkg::PROD_W-1:0] n1_ff, n1_in;
   logic [NC-1:0]                    neg1_ff, neg1_in;
   logic [NC-1:0][CW-1:0]            a1_ff;
   logic [pgf_pkg::RECIP_W-1:0]      r1_ff;
   logic [pgf_pkg::IDX_W-1:0]        idx1_ff;
   logic                             last1_ff;

   // stage 2: scaled quotient
   logic                             v2_ff;
   logic [NC-1:0][pgf_pkg::FULL_W-1:0] p2_ff, p2_in;
   logic [NC-1:0]                    neg2_ff;
   logic [NC-1:0][CW-1:0]            a2_ff;
   logic [pgf_pkg::IDX_W-1:0]        idx2_ff;
   logic                             last2_ff;

   // stage 3: output register
   logic                             v3_ff;
   logic [pgf_pkg::COLOR_W-1:0]      col3_ff, col3_in;
   logic [pgf_pkg::IDX_W-1:0]        idx3_ff;
   logic                             last3_ff;

   logic [NC-1:0][SW-1:0]            sum3;
   logic en1, en2, en3;

   assign en3        = !v3_ff || rsp_ch.ready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign work_ready = en1;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         logic [CW-1:0] a, b, mag;
         a          = work.start_color[c*CW +: CW];
         b          = work.end_color[c*CW +: CW];
         neg1_in[c] = (b < a);
         mag        = neg1_in[c] ? (a - b) : (b - a);
         n1_in[c]   = pgf_pkg::PROD_W'(work.k) * pgf_pkg::PROD_W'(mag);
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         p2_in[c] = pgf_pkg::FULL_W'(n1_ff[c]) * pgf_pkg::FULL_W'(r1_ff);
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         logic [pgf_pkg::PROD_W-1:0] q;
         q       = p2_ff[c][pgf_pkg::RECIP_SHIFT +: pgf_pkg::PROD_W];
         sum3[c] = neg2_ff[c] ? (SW'(a2_ff[c]) - SW'(q)) : (SW'(a2_ff[c]) + SW'(q));
         col3_in[c*CW +: CW] = sum3[c][CW-1:0] & pgf_pkg::CHAN_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= work_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         n1_ff    <= n1_in;
         neg1_ff  <= neg1_in;
         for (int c = 0; c < NC; c++) begin
            a1_ff[c] <= work.start_color[c*CW +: CW];
         end
         r1_ff    <= pgf_pkg::RECIP_TABLE[work.span];
         idx1_ff  <= work.index;
         last1_ff <= work.last;
      end
      if (en2) begin
         p2_ff    <= p2_in;
         neg2_ff  <= neg1_ff;
         a2_ff    <= a1_ff;
         idx2_ff  <= idx1_ff;
         last2_ff <= last1_ff;
      end
      if (en3) begin
         col3_ff  <= col3_in;
         idx3_ff  <= idx2_ff;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_ch.valid       = v3_ff;
   assign rsp_ch.entry_index = idx3_ff;
   assign rsp_ch.entry_color = col3_ff;
   assign rsp_ch.last_entry  = last3_ff;

   // interpolated channels never leave 0..15 when the reciprocal is exact
   a_chan_in_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ((sum3[0][SW-1:CW] == '0) && (sum3[1][SW-1:CW] == '0) &&
                 (sum3[2][SW-1:CW] == '0)))
      else $error("pgf_blend: channel out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && v3_ff && !rsp_ch.ready) |=> (v2_ff && $stable(idx2_ff)))
      else $error("pgf_blend: stage 2 entry lost under stall");

endmodule
